>>> sv/fxalu_pkg.sv
// Package for the Q17.14 fixed-point ALU: opcodes, defaults and the
// decoded control bundle that travels down the pipeline. No dependencies.
package fxalu_pkg;

  localparam int FracBitsDef = 14;
  localparam int DataBitsDef = 32;
  localparam int OpBits      = 4;

  typedef enum logic [OpBits-1:0] {
    OP_INT_TO_FIX = 4'd0,
    OP_TRUNC      = 4'd1,
    OP_ROUND      = 4'd2,
    OP_ADD        = 4'd3,
    OP_SUB        = 4'd4,
    OP_MUL        = 4'd5,
    OP_DIV        = 4'd6,
    OP_ADDI       = 4'd7,
    OP_SUBI       = 4'd8,
    OP_MULI       = 4'd9,
    OP_DIVI       = 4'd10
  } op_t;

  // Result source chosen at the end of the pipeline
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_SIMPLE = 2'd1,
    SRC_MUL = 2'd2,
    SRC_DIV = 2'd3
  } src_t;

  // Per-transaction control that follows the data
  typedef struct packed {
    src_t src;
    logic neg;
    logic mul_shift;
    logic dz;
  } ctl_t;

endpackage

>>> sv/fixed_point_q17_14_alu_unit.sv
// Fixed-point Q17.14 ALU: one transaction per cycle, pipeline depth is
// set by the divider,
// which produces one quotient bit per stage. All operations share that depth;
// the whole pipe stalls while a result waits in the output register.
// Uses fxalu_pkg, fxalu_mul and fxalu_div.
module fixed_point_q17_14_alu_unit #(
  parameter int FRAC_BITS = fxalu_pkg::FracBitsDef,
  parameter int DATA_BITS = fxalu_pkg::DataBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [3:0] opcode, [DATA_BITS+3:4] operand_a, [2*DATA_BITS+3:DATA_BITS+4] operand_b
  input  logic [((2*DATA_BITS+4+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [DATA_BITS-1:0] result, [DATA_BITS] status
  output logic [((DATA_BITS+1+7)/8)*8-1:0] out_tdata
);
  localparam int W   = DATA_BITS;
  localparam int QN  = W + FRAC_BITS;
  localparam int LAT = QN;
  localparam int OW  = ((W + 1 + 7) / 8) * 8;

  logic en;
  logic [LAT-1:0] vld_r;
  logic out_v_r;
  logic [W:0] out_r;

  // Stall whole pipe when the output register is full and not taken
  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  logic [3:0] op;
  logic signed [W-1:0] a, b;
  assign op = in_tdata[3:0];
  assign a  = in_tdata[W+3:4];
  assign b  = in_tdata[2*W+3:W+4];

  logic sa, sb;
  logic [W-1:0] ma, mb;
  assign sa = a[W-1];
  assign sb = b[W-1];
  assign ma = sa ? W'(-a) : a;
  assign mb = sb ? W'(-b) : b;

  // Stage 0: decode and simple ops
  logic [W-1:0] simple;
  logic [W-1:0] rnd;
  fxalu_pkg::ctl_t ctl;
  assign rnd = W'(({1'b0, ma} + (W+1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS);
  always_comb begin
    simple = '0;
    ctl = '{src: fxalu_pkg::SRC_ZERO, neg: sa ^ sb, mul_shift: 1'b0, dz: 1'b0};
    unique case (op) inside
      fxalu_pkg::OP_INT_TO_FIX: begin
        simple = a << FRAC_BITS; ctl.src = fxalu_pkg::SRC_SIMPLE;
      end
      fxalu_pkg::OP_TRUNC: begin
        simple = sa ? W'(-(ma >> FRAC_BITS)) : (ma >> FRAC_BITS);
        ctl.src = fxalu_pkg::SRC_SIMPLE;
      end
      fxalu_pkg::OP_ROUND: begin
        simple = sa ? W'(-rnd) : rnd; ctl.src = fxalu_pkg::SRC_SIMPLE;
      end
      fxalu_pkg::OP_ADD:  begin simple = a + b; ctl.src = fxalu_pkg::SRC_SIMPLE; end
      fxalu_pkg::OP_SUB:  begin simple = a - b; ctl.src = fxalu_pkg::SRC_SIMPLE; end
      fxalu_pkg::OP_ADDI: begin
        simple = a + (b << FRAC_BITS); ctl.src = fxalu_pkg::SRC_SIMPLE;
      end
      fxalu_pkg::OP_SUBI: begin
        simple = a - (b << FRAC_BITS); ctl.src = fxalu_pkg::SRC_SIMPLE;
      end
      fxalu_pkg::OP_MUL:  begin ctl.src = fxalu_pkg::SRC_MUL; ctl.mul_shift = 1'b1; end
      fxalu_pkg::OP_MULI: ctl.src = fxalu_pkg::SRC_MUL;
      fxalu_pkg::OP_DIV, fxalu_pkg::OP_DIVI: begin
        ctl.src = fxalu_pkg::SRC_DIV;
        ctl.dz  = (mb == '0);
      end
      default: ctl.src = fxalu_pkg::SRC_ZERO;
    endcase
  end

  // Divider operands: widened dividend for div, plain for divi
  logic [QN-1:0] dnum;
  assign dnum = (op == fxalu_pkg::OP_DIV) ? ({{FRAC_BITS{1'b0}}, ma} << FRAC_BITS)
                                          : QN'(ma);

  // Control, simple result and product delay lines to align with divider
  fxalu_pkg::ctl_t ctl_r [QN];
  logic [W-1:0] sim_r [QN];
  logic [2*W-1:0] prod_r [QN-2];
  logic [2*W-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl;
      sim_r[0] <= simple;
      for (int i = 1; i < QN; i++) begin
        ctl_r[i] <= ctl_r[i-1];
        sim_r[i] <= sim_r[i-1];
      end
      prod_r[0] <= prod;
      for (int i = 1; i < QN - 2; i++) prod_r[i] <= prod_r[i-1];
    end
  end

  fxalu_mul #(.W(W)) u_mul (
    .clk(clk), .en(en), .a(ma), .b(mb), .p(prod)
  );

  logic [W-1:0] dz_den;
  logic [QN-1:0] quo;
  assign dz_den = (mb == '0) ? W'(1) : mb;

  fxalu_div #(.N(QN), .D(W)) u_div (
    .clk(clk), .en(en), .num(dnum), .den(dz_den), .quo(quo)
  );

  // Final select and sign, into output register
  fxalu_pkg::ctl_t c;
  logic [W-1:0] mres, res;
  logic [2*W-1:0] pq;
  assign c  = ctl_r[QN-1];
  assign pq = prod_r[QN-3];
  always_comb begin
    mres = c.mul_shift ? W'(pq >> FRAC_BITS) : pq[W-1:0];
    case (c.src)
      fxalu_pkg::SRC_SIMPLE: res = sim_r[QN-1];
      fxalu_pkg::SRC_MUL:    res = c.neg ? W'(-mres) : mres;
      fxalu_pkg::SRC_DIV:    res = c.dz ? '0 : (c.neg ? W'(-quo[W-1:0]) : quo[W-1:0]);
      default:               res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[LAT-2:0], in_tvalid};
      out_v_r <= vld_r[QN-1];
    end
    if (en) out_r <= {c.src == fxalu_pkg::SRC_DIV && c.dz, res};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OW'(out_r);

`ifndef ASSERT_OFF
  // Nothing emerges from an empty pipe
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !vld_r[QN-1]) |=> !out_tvalid) else $error("spurious output");
  // Status only set with a zero result
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[W]) |-> (out_tdata[W-1:0] == '0)) else $error("bad status");
  // Stall holds output
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && out_tvalid))
    else $error("output changed while stalled");
`endif
endmodule

>>> sv/fxalu_mul.sv
// Pipelined unsigned magnitude multiplier, product split into four
// partial products over two stages. Default width from fxalu_pkg.
module fxalu_mul #(
  parameter int W = fxalu_pkg::DataBitsDef
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);
  localparam int H = (W + 1) / 2;
  localparam int L = W - H;

  logic [2*H-1:0] hh_r, hl_r, lh_r, ll_r;
  logic [2*W-1:0] p_r;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= (2*H)'(a[W-1:L]) * (2*H)'(b[W-1:L]);
      hl_r <= (2*H)'(a[W-1:L]) * (2*H)'(b[L-1:0]);
      lh_r <= (2*H)'(a[L-1:0]) * (2*H)'(b[W-1:L]);
      ll_r <= (2*H)'(a[L-1:0]) * (2*H)'(b[L-1:0]);
    end
  end

  // Stage 2: sum of shifted partials
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ((2*W)'(hh_r) << (2*L)) + ((2*W)'(hl_r) << L)
           + ((2*W)'(lh_r) << L) + (2*W)'(ll_r);
    end
  end

  assign p = p_r;
endmodule

>>> sv/fxalu_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned
// magnitudes. Quotient is N bits wide. Default widths from fxalu_pkg.
module fxalu_div #(
  parameter int N = fxalu_pkg::DataBitsDef + fxalu_pkg::FracBitsDef,
  parameter int D = fxalu_pkg::DataBitsDef
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] num,
  input  logic [D-1:0] den,
  output logic [N-1:0] quo
);
  logic [N-1:0] q_r [N+1];
  logic [D-1:0] r_r [N+1];
  logic [D-1:0] d_r [N+1];

  assign q_r[0] = num;
  assign r_r[0] = '0;
  assign d_r[0] = den;

  // One stage per quotient bit: shift in a dividend bit, try subtract
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [D:0] trial;
    assign trial = {r_r[i], q_r[i][N-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_r[i];
        if (trial >= {1'b0, d_r[i]}) begin
          r_r[i+1] <= D'(trial - {1'b0, d_r[i]});
          q_r[i+1] <= {q_r[i][N-2:0], 1'b1};
        end else begin
          r_r[i+1] <= trial[D-1:0];
          q_r[i+1] <= {q_r[i][N-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[N];
endmodule

>>> dv/fixed_point_q17_14_alu_unit_tb.sv
// Testbench for the Q17.14 fixed-point ALU: directed corners plus random
// opcode/operand streams, checked in order against a behavioral predictor.
// Depends on fxalu_pkg and the fixed_point_q17_14_alu_unit RTL.
module fixed_point_q17_14_alu_unit_tb;

  localparam int FB = fxalu_pkg::FracBitsDef;
  localparam int DB = fxalu_pkg::DataBitsDef;
  localparam int IN_W = ((2*DB+4+7)/8)*8;
  localparam int OUT_W = ((DB+1+7)/8)*8;
  localparam int N_RANDOM = 1850;
  localparam int WDOG_LIMIT = 2000;

  typedef struct packed {
    logic        status;
    logic [31:0] result;
  } alu_res_t;

  // Behavioral model of the ALU; operands are treated as signed 32-bit words
  function automatic alu_res_t predict_alu(logic [3:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    logic signed [127:0] wa, wb, q;
    alu_res_t r;
    wa = a;
    wb = b;
    r = '0;
    case (op)
      fxalu_pkg::OP_INT_TO_FIX: r.result = a <<< FB;
      fxalu_pkg::OP_TRUNC: begin
        q = wa / (128'sd1 <<< FB);
        r.result = q[31:0];
      end
      fxalu_pkg::OP_ROUND: begin
        // half away from zero on the magnitude
        if (a < 0) q = -((-wa + (128'sd1 <<< (FB-1))) >>> FB);
        else       q = (wa + (128'sd1 <<< (FB-1))) >>> FB;
        r.result = q[31:0];
      end
      fxalu_pkg::OP_ADD:  r.result = a + b;
      fxalu_pkg::OP_SUB:  r.result = a - b;
      fxalu_pkg::OP_MUL: begin
        q = (wa * wb) / (128'sd1 <<< FB);
        r.result = q[31:0];
      end
      fxalu_pkg::OP_DIV: begin
        if (b == 0) r.status = 1'b1;
        else begin
          q = (wa <<< FB) / wb;
          r.result = q[31:0];
        end
      end
      fxalu_pkg::OP_ADDI: r.result = a + (b <<< FB);
      fxalu_pkg::OP_SUBI: r.result = a - (b <<< FB);
      fxalu_pkg::OP_MULI: r.result = a * b;
      fxalu_pkg::OP_DIVI: begin
        if (b == 0) r.status = 1'b1;
        else begin
          q = wa / wb;
          r.result = q[31:0];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // In-order store of expected ALU results
  class alu_scoreboard;
    alu_res_t pending[$];
    int errors;
    int checked;

    function void note_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      pending.push_back(predict_alu(op, a, b));
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      alu_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (data[31:0] !== exp_r.result) begin
        $display("%0t: result mismatch exp %h got %h", $time, exp_r.result, data[31:0]);
        errors++;
      end
      if (data[32] !== exp_r.status) begin
        $display("%0t: status mismatch exp %b got %b", $time, exp_r.status, data[32]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  alu_scoreboard sb;
  int idle_cycles = 0;
  bit stim_done;
  int op_hits[16];

  fixed_point_q17_14_alu_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one operation; waits a random gap first
  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({b, a, op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(op, a, b);
    op_hits[op]++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(0);
      3: return 32'(signed'($urandom_range(0, 80000)) - 40000);
      4: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< FB;
      5: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Result side: random backpressure, check every transaction
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] corners[6];
    int wait_cnt;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_2000,
                32'hffff_e000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every opcode incl. unused ones, rounding ties, zero divisors
    for (int op = 0; op < 16; op++) send_op(op[3:0], corners[op % 6], 32'h7fff_ffff);
    send_op(fxalu_pkg::OP_DIV, 32'h0001_0000, 32'h0);
    send_op(fxalu_pkg::OP_DIVI, 32'h8000_0000, 32'hffff_ffff);
    send_op(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(fxalu_pkg::OP_ROUND, 32'hffff_e000, 32'h1234_5678);
    send_op(fxalu_pkg::OP_DIVI, 32'h7fff_ffff, 32'h0);

    // Random: mostly legal opcodes with a few unused ones
    for (int i = 0; i < N_RANDOM; i++) begin
      logic [3:0] op;
      logic [31:0] b;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(0, 10));
      b = rand_operand();
      if ((op == fxalu_pkg::OP_DIV || op == fxalu_pkg::OP_DIVI) &&
          $urandom_range(0, 9) == 0) b = '0;
      send_op(op, rand_operand(), b);
    end
    in_tvalid <= 1'b0;

    // Drain, then allow the pipeline latency to pass
    wait_cnt = 0;
    while (sb.pending.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (FB + DB + 10) @(posedge clk);
    $display("Covered %0d transactions over all 16 opcodes, %0d of them divides",
             sb.checked, op_hits[fxalu_pkg::OP_DIV] + op_hits[fxalu_pkg::OP_DIVI]);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
